@@ design/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants
// Channel widths, the fixed-point hue scale, the hue sector code and the
// lane record that moves down the divider cell chain.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int CH_W   = 8;             // channel byte width
   localparam int HUE_W  = 15;            // hue output width
   localparam int QUO_W  = 12;            // quotient bits, covers 0..3840
   localparam int REM_W  = 20;            // partial remainder width
   localparam int DIFF_W = CH_W + 1;      // signed channel difference
   localparam int HSUM_W = HUE_W + 2;     // signed hue before wrap

   localparam int HUE_SIXTY = 3840;       // 60 degrees in 1/64 degree
   localparam int HUE_FULL  = 23040;      // 360 degrees in 1/64 degree
   localparam int SAT_SCALE = 255;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // Everything one pixel carries through the divider chain
   typedef struct packed {
      logic [REM_W-1:0] hue_rem;
      logic [CH_W-1:0]  hue_div;
      logic [QUO_W-1:0] hue_quo;
      logic [REM_W-1:0] sat_rem;
      logic [CH_W-1:0]  sat_div;
      logic [QUO_W-1:0] sat_quo;
      logic             hue_neg;
      sector_type       sector;
      logic             gray;
      logic [CH_W-1:0]  brightness;
      logic [CH_W-1:0]  alpha;
   } lane_type;

endpackage

@@ design/rhc_front.sv @@
// ----------------------------------------------------------------------------
// rhc_front: max/min and numerator setup
// Stage 1 finds max, min, sector and the signed channel difference.
// Stage 2 forms delta, the two scaled numerators and loads the lane record.
// ----------------------------------------------------------------------------
module rhc_front
   import rhc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [CH_W-1:0] red,
   input  logic [CH_W-1:0] green,
   input  logic [CH_W-1:0] blue,
   input  logic [CH_W-1:0] alpha,
   output logic            out_valid,
   output lane_type        out_lane
);

   logic                     s1_valid_ff;
   logic [CH_W-1:0]          s1_max_ff, s1_max_in;
   logic [CH_W-1:0]          s1_min_ff, s1_min_in;
   sector_type               s1_sector_ff, s1_sector_in;
   logic signed [DIFF_W-1:0] s1_diff_ff, s1_diff_in;
   logic [CH_W-1:0]          s1_alpha_ff;

   logic                     s2_valid_ff;
   lane_type                 s2_lane_ff, s2_lane_in;

   logic [CH_W-1:0]          delta;
   logic [CH_W-1:0]          mag;
   logic                     neg;

   always_comb begin
      s1_max_in = red;
      if (green > s1_max_in) s1_max_in = green;
      if (blue > s1_max_in)  s1_max_in = blue;
      s1_min_in = red;
      if (green < s1_min_in) s1_min_in = green;
      if (blue < s1_min_in)  s1_min_in = blue;

      // ties go red, then green, then blue
      if (s1_max_in == red) begin
         s1_sector_in = SECTOR_RED;
         s1_diff_in   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (s1_max_in == green) begin
         s1_sector_in = SECTOR_GREEN;
         s1_diff_in   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         s1_sector_in = SECTOR_BLUE;
         s1_diff_in   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_max_ff    <= s1_max_in;
      s1_min_ff    <= s1_min_in;
      s1_sector_ff <= s1_sector_in;
      s1_diff_ff   <= s1_diff_in;
      s1_alpha_ff  <= alpha;
      s2_lane_ff   <= s2_lane_in;
   end

   // truncation toward zero: divide the magnitude, restore the sign later
   always_comb begin
      delta = s1_max_ff - s1_min_ff;
      neg   = s1_diff_ff[DIFF_W-1];
      mag   = neg ? CH_W'(-s1_diff_ff) : CH_W'(s1_diff_ff);

      s2_lane_in            = '0;
      s2_lane_in.hue_rem    = REM_W'(mag) * REM_W'(HUE_SIXTY);
      s2_lane_in.hue_div    = delta;
      s2_lane_in.sat_rem    = REM_W'(delta) * REM_W'(SAT_SCALE);
      s2_lane_in.sat_div    = s1_max_ff;
      s2_lane_in.hue_neg    = neg;
      s2_lane_in.sector     = s1_sector_ff;
      s2_lane_in.gray       = (delta == '0);
      s2_lane_in.brightness = s1_max_ff;
      s2_lane_in.alpha      = s1_alpha_ff;
   end

   assign out_valid = s2_valid_ff;
   assign out_lane  = s2_lane_ff;

endmodule

@@ design/rhc_cell.sv @@
// ----------------------------------------------------------------------------
// rhc_cell: one restoring division step
// Resolves one quotient bit for both the hue and the saturation division
// and hands the updated lane record to the next cell.
// ----------------------------------------------------------------------------
module rhc_cell
   import rhc_pkg::*;
#(
   parameter int BIT_POS = QUO_W - 1
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  lane_type in_lane,
   output logic     out_valid,
   output lane_type out_lane
);

   logic     valid_ff;
   lane_type lane_ff, lane_in;

   logic [REM_W-1:0] hue_sh;
   logic [REM_W-1:0] sat_sh;

   always_comb begin
      hue_sh  = REM_W'(in_lane.hue_div) << BIT_POS;
      sat_sh  = REM_W'(in_lane.sat_div) << BIT_POS;
      lane_in = in_lane;
      if (in_lane.hue_rem >= hue_sh) begin
         lane_in.hue_rem          = in_lane.hue_rem - hue_sh;
         lane_in.hue_quo[BIT_POS] = 1'b1;
      end
      if (in_lane.sat_rem >= sat_sh) begin
         lane_in.sat_rem          = in_lane.sat_rem - sat_sh;
         lane_in.sat_quo[BIT_POS] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

@@ design/rhc_back.sv @@
// ----------------------------------------------------------------------------
// rhc_back: hue assembly and output register
// Applies sign and sector offset, wraps negative hue, forces gray to zero.
// ----------------------------------------------------------------------------
module rhc_back
   import rhc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  lane_type         in_lane,
   output logic             out_valid,
   output logic [HUE_W-1:0] hue,
   output logic [CH_W-1:0]  saturation,
   output logic [CH_W-1:0]  brightness,
   output logic [CH_W-1:0]  alpha
);

   logic                     valid_ff;
   logic [HUE_W-1:0]         hue_ff, hue_in;
   logic [CH_W-1:0]          sat_ff, sat_in;
   logic [CH_W-1:0]          bright_ff;
   logic [CH_W-1:0]          alpha_ff;

   logic signed [HSUM_W-1:0] offset;
   logic signed [HSUM_W-1:0] quo;
   logic signed [HSUM_W-1:0] hsum;

   always_comb begin
      case (in_lane.sector)
         SECTOR_RED:   offset = '0;
         SECTOR_GREEN: offset = HSUM_W'(2 * HUE_SIXTY);
         SECTOR_BLUE:  offset = HSUM_W'(4 * HUE_SIXTY);
         default:      offset = '0;
      endcase
      quo  = $signed(HSUM_W'(in_lane.hue_quo));
      hsum = in_lane.hue_neg ? offset - quo : offset + quo;
      if (hsum < 0) hsum = hsum + HSUM_W'(HUE_FULL);

      if (in_lane.gray) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = HUE_W'(hsum);
         sat_in = CH_W'(in_lane.sat_quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      hue_ff    <= hue_in;
      sat_ff    <= sat_in;
      bright_ff <= in_lane.brightness;
      alpha_ff  <= in_lane.alpha;
   end

   assign out_valid  = valid_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign brightness = bright_ff;
   assign alpha      = alpha_ff;

endmodule

@@ design/rgb_to_hsv_converter_top.sv @@
// Pipeline: 2 setup stages, 12 divider cells at one quotient bit each and
// 1 output stage lie between an accepted request and rsp_valid.
// Throughput: one request per cycle; busy is never raised.
// Reset: synchronous, clears all valid flags so no response follows reset.
// Responses are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top: RGB to HSV pixel converter
// Max/min front end, a chain of restoring divider cells for hue and
// saturation, and a back end that applies sector offset and wrap.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top
   import rhc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [CH_W-1:0]  req_red,
   input  logic [CH_W-1:0]  req_green,
   input  logic [CH_W-1:0]  req_blue,
   input  logic [CH_W-1:0]  req_alpha_in,
   output logic             rsp_valid,
   output logic [HUE_W-1:0] rsp_hue,
   output logic [CH_W-1:0]  rsp_saturation,
   output logic [CH_W-1:0]  rsp_brightness,
   output logic [CH_W-1:0]  rsp_alpha_out
);

   logic     chain_valid [QUO_W+1];
   lane_type chain_lane  [QUO_W+1];

   assign busy = 1'b0;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .alpha     (req_alpha_in),
      .out_valid (chain_valid[0]),
      .out_lane  (chain_lane[0])
   );

   // cell k resolves quotient bit QUO_W-1-k
   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      rhc_cell #(
         .BIT_POS (QUO_W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_lane   (chain_lane[k]),
         .out_valid (chain_valid[k+1]),
         .out_lane  (chain_lane[k+1])
      );
   end

   rhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[QUO_W]),
      .in_lane    (chain_lane[QUO_W]),
      .out_valid  (rsp_valid),
      .hue        (rsp_hue),
      .saturation (rsp_saturation),
      .brightness (rsp_brightness),
      .alpha      (rsp_alpha_out)
   );

endmodule

@@ verif/hsv_checker.sv @@
// ----------------------------------------------------------------------------
// hsv_checker: response checker for the RGB to HSV converter
// Watches the request and response ports, predicts hue, saturation,
// brightness and alpha for every accepted pixel, and compares each response
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module hsv_checker
   import rhc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic [CH_W-1:0]  req_red,
   input  logic [CH_W-1:0]  req_green,
   input  logic [CH_W-1:0]  req_blue,
   input  logic [CH_W-1:0]  req_alpha_in,
   input  logic             rsp_valid,
   input  logic [HUE_W-1:0] rsp_hue,
   input  logic [CH_W-1:0]  rsp_saturation,
   input  logic [CH_W-1:0]  rsp_brightness,
   input  logic [CH_W-1:0]  rsp_alpha_out,
   output int               error_count,
   output int               outstanding
);

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  saturation;
      logic [CH_W-1:0]  brightness;
      logic [CH_W-1:0]  alpha;
   } hsv_pixel_type;

   hsv_pixel_type expected_hsv[$];
   int            mismatches;

   function automatic hsv_pixel_type hsv_of_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                                  logic [CH_W-1:0] b, logic [CH_W-1:0] a);
      int            ri;
      int            gi;
      int            bi;
      int            vmax;
      int            vmin;
      int            delta;
      int            h;
      int            s;
      sector_type    sector;
      hsv_pixel_type px;
      ri     = r;
      gi     = g;
      bi     = b;
      vmax   = ri;
      vmin   = ri;
      sector = SECTOR_RED;
      if (gi > vmax) begin
         vmax   = gi;
         sector = SECTOR_GREEN;
      end
      if (bi > vmax) begin
         vmax   = bi;
         sector = SECTOR_BLUE;
      end
      if (gi < vmin) vmin = gi;
      if (bi < vmin) vmin = bi;
      delta = vmax - vmin;
      h     = 0;
      s     = 0;
      // gray pixels keep hue and saturation at zero
      if (delta > 0) begin
         case (sector)
            SECTOR_RED:   h = (HUE_SIXTY * (gi - bi)) / delta;
            SECTOR_GREEN: h = (HUE_SIXTY * (bi - ri)) / delta + 2 * HUE_SIXTY;
            default:      h = (HUE_SIXTY * (ri - gi)) / delta + 4 * HUE_SIXTY;
         endcase
         if (h < 0) h += HUE_FULL;
         s = (SAT_SCALE * delta) / vmax;
      end
      px.hue        = h[HUE_W-1:0];
      px.saturation = s[CH_W-1:0];
      px.brightness = vmax[CH_W-1:0];
      px.alpha      = a;
      return px;
   endfunction

   always @(posedge clock) begin
      hsv_pixel_type want;
      hsv_pixel_type got;
      if (reset) begin
         expected_hsv.delete();
         mismatches = 0;
      end else begin
         if (start && !busy)
            expected_hsv.push_back(hsv_of_pixel(req_red, req_green, req_blue, req_alpha_in));
         if (rsp_valid) begin
            got = {rsp_hue, rsp_saturation, rsp_brightness, rsp_alpha_out};
            if (expected_hsv.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response hue=%0d sat=%0d val=%0d alpha=%0d",
                           $realtime, rsp_hue, rsp_saturation, rsp_brightness,
                           rsp_alpha_out);
            end else begin
               want = expected_hsv.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display(
                        "%0t: exp h=%0d s=%0d v=%0d a=%0d got h=%0d s=%0d v=%0d a=%0d",
                        $realtime, want.hue, want.saturation, want.brightness,
                        want.alpha, got.hue, got.saturation, got.brightness,
                        got.alpha);
               end
            end
         end
      end
      error_count <= mismatches;
      outstanding <= expected_hsv.size();
   end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: RGB to HSV converter testbench
// Drives directed corner pixels (gray, primaries, channel ties, negative hue
// wrap, minimal deltas), then random pixels with random or no request gaps.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
   import rhc_pkg::*;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [CH_W-1:0]  req_red;
   logic [CH_W-1:0]  req_green;
   logic [CH_W-1:0]  req_blue;
   logic [CH_W-1:0]  req_alpha_in;
   logic             rsp_valid;
   logic [HUE_W-1:0] rsp_hue;
   logic [CH_W-1:0]  rsp_saturation;
   logic [CH_W-1:0]  rsp_brightness;
   logic [CH_W-1:0]  rsp_alpha_out;
   int               error_count;
   int               outstanding;
   bit               burst_mode;

   rgb_to_hsv_converter_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_alpha_in   (req_alpha_in),
      .rsp_valid      (rsp_valid),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness),
      .rsp_alpha_out  (rsp_alpha_out)
   );

   hsv_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_alpha_in   (req_alpha_in),
      .rsp_valid      (rsp_valid),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness),
      .rsp_alpha_out  (rsp_alpha_out),
      .error_count    (error_count),
      .outstanding    (outstanding)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // issue one pixel request and hold it until the block takes it
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a);
      int gap;
      req_red      <= r;
      req_green    <= g;
      req_blue     <= b;
      req_alpha_in <= a;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = burst_mode ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] edge_byte();
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   function automatic logic [7:0] near_byte(logic [7:0] base);
      int v;
      v = int'(base) + $urandom_range(0, 6) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   logic [31:0] corner_pixels[] = '{
      {8'd0,   8'd0,   8'd0,   8'd0},
      {8'd255, 8'd255, 8'd255, 8'd255},
      {8'd128, 8'd128, 8'd128, 8'd77},
      {8'd1,   8'd1,   8'd1,   8'd170},
      {8'd255, 8'd0,   8'd0,   8'd85},
      {8'd0,   8'd255, 8'd0,   8'd255},
      {8'd0,   8'd0,   8'd255, 8'd0},
      {8'd255, 8'd255, 8'd0,   8'd1},
      {8'd0,   8'd255, 8'd255, 8'd254},
      {8'd255, 8'd0,   8'd255, 8'd128},
      {8'd255, 8'd0,   8'd1,   8'd127},
      {8'd1,   8'd0,   8'd0,   8'd2},
      {8'd0,   8'd1,   8'd0,   8'd4},
      {8'd0,   8'd0,   8'd1,   8'd8},
      {8'd1,   8'd0,   8'd1,   8'd16},
      {8'd255, 8'd254, 8'd254, 8'd32},
      {8'd254, 8'd255, 8'd0,   8'd64},
      {8'd0,   8'd128, 8'd255, 8'd200},
      {8'd200, 8'd100, 8'd50,  8'd100},
      {8'd170, 8'd85,  8'd255, 8'd55},
      {8'd2,   8'd1,   8'd3,   8'd99},
      {8'd128, 8'd127, 8'd129, 8'd240}
   };

   initial begin
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] base;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_red      <= '0;
      req_green    <= '0;
      req_blue     <= '0;
      req_alpha_in <= '0;
      burst_mode   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_pixels[i])
         send_pixel(corner_pixels[i][31:24], corner_pixels[i][23:16],
                    corner_pixels[i][15:8], corner_pixels[i][7:0]);

      for (int n = 0; n < 1400; n++) begin
         // alternate stretches of back-to-back requests and random gaps
         if (n % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 9))
            6: begin
               r = $urandom_range(0, 255);
               g = r;
               b = r;
            end
            7: begin
               base = $urandom_range(0, 255);
               r = base;
               g = base;
               b = $urandom_range(0, 255);
               case ($urandom_range(0, 2))
                  0: {r, g, b} = {base, base, b};
                  1: {r, g, b} = {b, base, base};
                  default: {r, g, b} = {base, b, base};
               endcase
            end
            8: begin
               base = $urandom_range(0, 255);
               r = near_byte(base);
               g = near_byte(base);
               b = near_byte(base);
            end
            9: begin
               r = edge_byte();
               g = edge_byte();
               b = edge_byte();
            end
            default: begin
               r = $urandom_range(0, 255);
               g = $urandom_range(0, 255);
               b = $urandom_range(0, 255);
            end
         endcase
         send_pixel(r, g, b, $urandom_range(0, 255));
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
